### sv/mcir_pkg.sv
// Package with payload types, MIDI constants and reply byte table for the crossover responder.
`timescale 1ns / 1ps

package mcir_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 42;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned REPLY_IDX_W = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_ANSWER_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDENTITY_BYTES  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] IDENTITY_RESET = 42'd270532657;

  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] UNIV_NON_RT   = 8'h7E;
  localparam logic [7:0] SUB_GEN_INFO  = 8'h06;
  localparam logic [7:0] SUB_ID_REQ    = 8'h01;
  localparam logic [7:0] SUB_ID_REPLY  = 8'h02;
  localparam logic [7:0] MFR_ID_BYTE   = 8'h3F;

  localparam logic [COUNT_W-1:0]     COUNT_MAX   = 5'd31;
  localparam logic [COUNT_W-1:0]     REQ_BODY_LEN = 5'd4;
  localparam logic [REPLY_IDX_W-1:0] REPLY_LAST  = 5'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_port;
    logic       peer_listening;
    logic       main_listening;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_port;
    logic       is_reply;
    logic       last;
  } rsp_t;

  function automatic logic [7:0] reply_byte(input logic [REPLY_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] ident);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      5'd0:    b = SYSEX_START;
      5'd1:    b = UNIV_NON_RT;
      5'd2:    b = 8'h00;
      5'd3:    b = SUB_GEN_INFO;
      5'd4:    b = SUB_ID_REPLY;
      5'd5:    b = 8'h00;
      5'd6:    b = SUB_ID_REQ;
      5'd7:    b = MFR_ID_BYTE;
      5'd8:    b = MFR_ID_BYTE;
      5'd9:    b = {1'b0, ident[41:35]};
      5'd10:   b = {1'b0, ident[34:28]};
      5'd11:   b = {1'b0, ident[27:21]};
      5'd12:   b = {1'b0, ident[20:14]};
      5'd13:   b = {1'b0, ident[13:7]};
      5'd14:   b = {1'b0, ident[6:0]};
      5'd15:   b = 8'h00;
      5'd16:   b = SYSEX_END;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### sv/mcir_scan.sv
// SysEx scanner that detects a Universal Identity Request on port-0 words.
`timescale 1ns / 1ps

module mcir_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               answer_enable,
  input  mcir_pkg::req_t     req,
  output logic               answer
);

  logic                              in_sysex;
  logic [mcir_pkg::COUNT_W-1:0]      body_count;
  logic [7:0]                        header_bytes [4];
  logic                              scan;
  logic                              is_start;
  logic                              is_end;
  logic                              header_match;

  assign scan     = accept && answer_enable && !req.from_port;
  assign is_start = req.data_byte == mcir_pkg::SYSEX_START;
  assign is_end   = req.data_byte == mcir_pkg::SYSEX_END;

  assign header_match = (body_count == mcir_pkg::REQ_BODY_LEN) &&
                        (header_bytes[0] == mcir_pkg::UNIV_NON_RT) &&
                        (header_bytes[2] == mcir_pkg::SUB_GEN_INFO) &&
                        (header_bytes[3] == mcir_pkg::SUB_ID_REQ);

  assign answer = scan && !is_start && in_sysex && is_end && header_match &&
                  req.main_listening;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex   <= 1'b0;
      body_count <= '0;
    end else if (scan) begin
      if (is_start) begin
        in_sysex   <= 1'b1;
        body_count <= '0;
      end else if (in_sysex) begin
        if (is_end) begin
          in_sysex   <= 1'b0;
          body_count <= '0;
        end else if (body_count != mcir_pkg::COUNT_MAX) begin
          body_count <= body_count + 5'd1;
        end
      end
    end
  end

  // capture the first four body bytes
  always_ff @(posedge clk) begin
    if (scan && !is_start && in_sysex && !is_end &&
        (body_count < mcir_pkg::REQ_BODY_LEN)) begin
      header_bytes[body_count[1:0]] <= req.data_byte;
    end
  end

endmodule

### sv/midi_crossover_identity_responder.sv
// Top level of the MIDI crossover with Universal Identity Request responder.
//
// Usage: each word on the req channel is one MIDI byte written to port 0 or 1.
// When peer_listening is set the byte comes out on rsp addressed to the other
// port. Port-0 bytes are scanned for SysEx while answer_enable is set; a closed
// body of 7E xx 06 01 with main_listening set adds the 17-word identity reply
// to port 0 after the forwarded copy. The last word of each item carries last;
// an item that yields nothing produces no rsp word.
// Configuration: cfg_index 0 is answer_enable, 1 is the six identity bytes.
// Writes are always taken; unknown indexes are dropped.
// Path: the first rsp word of an item is registered in the job register and then
// in the output register.
// Throughput: one req word per cycle while each item yields at most one word
// and rsp is not stalled; an item with a reply sends its 17 or 18 words one per
// cycle while rsp_ready is high and holds req_ready low until its last word goes.
// Stall: while rsp_ready is low the output word holds and the job waits; req
// is still taken while the job slot is free.
// Reset: synchronous rst clears the scanner, the job slot and the output.
`timescale 1ns / 1ps

module midi_crossover_identity_responder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  mcir_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output mcir_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcir_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mcir_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                                 answer_enable;
  logic [mcir_pkg::CFG_DATA_W-1:0]      identity_free_bytes;

  logic                                 job_valid;
  logic                                 job_fwd;
  logic                                 job_reply;
  logic [7:0]                           job_byte;
  logic                                 job_port;
  logic [mcir_pkg::REPLY_IDX_W-1:0]     job_idx;

  logic                                 accept;
  logic                                 answer;
  logic                                 load_ok;
  logic                                 emit;
  logic                                 emit_last;
  logic                                 job_done;
  mcir_pkg::rsp_t                       rsp_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_enable       <= 1'b0;
      identity_free_bytes <= mcir_pkg::IDENTITY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mcir_pkg::CFG_ANSWER_ENABLE:  answer_enable       <= cfg_data[0];
        mcir_pkg::CFG_IDENTITY_BYTES: identity_free_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  mcir_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .answer_enable (answer_enable),
    .req           (req),
    .answer        (answer)
  );

  assign load_ok   = !rsp_valid || rsp_ready;
  assign emit      = job_valid && load_ok;
  assign emit_last = job_fwd ? !job_reply : (job_idx == mcir_pkg::REPLY_LAST);
  assign job_done  = emit && emit_last;
  assign req_ready = !job_valid || job_done;
  assign accept    = req_valid && req_ready;

  always_comb begin
    if (job_fwd) begin
      rsp_next.out_byte = job_byte;
      rsp_next.to_port  = job_port;
      rsp_next.is_reply = 1'b0;
    end else begin
      rsp_next.out_byte = mcir_pkg::reply_byte(job_idx, identity_free_bytes);
      rsp_next.to_port  = 1'b0;
      rsp_next.is_reply = 1'b1;
    end
    rsp_next.last = emit_last;
  end

  // advance the job one word per emit; a new item overwrites a finished job
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_fwd   <= 1'b0;
      job_reply <= 1'b0;
      job_idx   <= '0;
    end else if (accept) begin
      job_valid <= req.peer_listening || answer;
      job_fwd   <= req.peer_listening;
      job_reply <= answer;
      job_idx   <= '0;
    end else begin
      if (job_done) begin
        job_valid <= 1'b0;
      end
      if (emit) begin
        if (job_fwd) begin
          job_fwd <= 1'b0;
        end else begin
          job_idx <= job_idx + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_byte <= req.data_byte;
      job_port <= ~req.from_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

### sim/midi_crossover_identity_checker.sv
// Checker for the MIDI crossover identity responder: predicts and compares rsp words.
`timescale 1ns / 1ps

module midi_crossover_identity_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_ready,
  input  mcir_pkg::req_t                   req,
  input  logic                             rsp_valid,
  input  logic                             rsp_ready,
  input  mcir_pkg::rsp_t                   rsp,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mcir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcir_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      errors,
  output int unsigned                      pending
);

  logic                            answer_en;
  logic [mcir_pkg::CFG_DATA_W-1:0] ident_bits;
  logic                            in_msg;
  logic [mcir_pkg::COUNT_W-1:0]    body_len;
  logic [7:0]                      header [4];
  mcir_pkg::rsp_t                  expected_words [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic mcir_pkg::rsp_t make_word(input logic [7:0] b, input logic port,
                                               input logic reply, input logic fin);
    mcir_pkg::rsp_t w;
    w.out_byte = b;
    w.to_port  = port;
    w.is_reply = reply;
    w.last     = fin;
    return w;
  endfunction

  function automatic logic [7:0] identity_reply_byte(input int k);
    logic [mcir_pkg::CFG_DATA_W-1:0] field;
    logic [7:0]                      b;
    b = 8'h00;
    case (k)
      0: b = mcir_pkg::SYSEX_START;
      1: b = mcir_pkg::UNIV_NON_RT;
      3: b = mcir_pkg::SUB_GEN_INFO;
      4: b = mcir_pkg::SUB_ID_REPLY;
      6: b = 8'h01;
      7, 8: b = mcir_pkg::MFR_ID_BYTE;
      16: b = mcir_pkg::SYSEX_END;
      default: begin
        if (k >= 9 && k <= 14) begin
          field = ident_bits >> (7 * (14 - k));
          b = {1'b0, field[6:0]};
        end
      end
    endcase
    return b;
  endfunction

  task automatic predict_deliveries(input mcir_pkg::req_t w);
    logic answer;
    answer = 1'b0;
    if (answer_en && !w.from_port) begin
      if (w.data_byte == mcir_pkg::SYSEX_START) begin
        in_msg = 1'b1;
        body_len = '0;
      end else if (in_msg) begin
        if (w.data_byte != mcir_pkg::SYSEX_END) begin
          if (body_len < mcir_pkg::REQ_BODY_LEN)
            header[body_len[1:0]] = w.data_byte;
          if (body_len != mcir_pkg::COUNT_MAX)
            body_len = body_len + 1'b1;
        end else begin
          answer = (body_len == mcir_pkg::REQ_BODY_LEN) &&
                   (header[0] == mcir_pkg::UNIV_NON_RT) &&
                   (header[2] == mcir_pkg::SUB_GEN_INFO) &&
                   (header[3] == mcir_pkg::SUB_ID_REQ) &&
                   w.main_listening;
          in_msg = 1'b0;
          body_len = '0;
        end
      end
    end
    if (w.peer_listening)
      expected_words.push_back(make_word(w.data_byte, ~w.from_port, 1'b0, ~answer));
    if (answer)
      for (int k = 0; k <= mcir_pkg::REPLY_LAST; k++)
        expected_words.push_back(make_word(identity_reply_byte(k), 1'b0, 1'b1,
                                           k == mcir_pkg::REPLY_LAST));
  endtask

  always @(posedge clk) begin : watch
    mcir_pkg::rsp_t want;
    if (rst) begin
      answer_en = 1'b0;
      ident_bits = mcir_pkg::IDENTITY_RESET;
      in_msg = 1'b0;
      body_len = '0;
      expected_words.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: rsp word with nothing expected: expected none, got byte %02h",
                   $time, rsp.out_byte, " port %0d reply %0d last %0d",
                   rsp.to_port, rsp.is_reply, rsp.last);
        end else begin
          want = expected_words.pop_front();
          if (rsp !== want) begin
            errors++;
            $display("%0t: rsp word mismatch: expected byte %02h port %0d reply %0d last %0d",
                     $time, want.out_byte, want.to_port, want.is_reply, want.last);
            $display("%0t:                    actual   byte %02h port %0d reply %0d last %0d",
                     $time, rsp.out_byte, rsp.to_port, rsp.is_reply, rsp.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mcir_pkg::CFG_ANSWER_ENABLE:  answer_en = cfg_data[0];
          mcir_pkg::CFG_IDENTITY_BYTES: ident_bits = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready)
        predict_deliveries(req);
    end
    pending = expected_words.size();
  end

endmodule

### sim/tb_midi_crossover_identity_responder.sv
// Testbench top for the MIDI crossover identity responder: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_midi_crossover_identity_responder;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             req_valid = 1'b0;
  logic                             req_ready;
  mcir_pkg::req_t                   req = '0;
  logic                             rsp_valid;
  logic                             rsp_ready = 1'b0;
  mcir_pkg::rsp_t                   rsp;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mcir_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mcir_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  int unsigned                      errors;
  int unsigned                      pending;
  int unsigned                      words_sent = 0;
  int unsigned                      send_idle_pct = 0;
  int unsigned                      stall_pct = 0;

  midi_crossover_identity_responder i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  midi_crossover_identity_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [7:0] rand_byte(input int unsigned hi);
    return 8'($urandom_range(hi));
  endfunction

  function automatic logic [mcir_pkg::CFG_DATA_W-1:0] rand_ident();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[mcir_pkg::CFG_DATA_W-1:0];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic port, input logic peer,
                           input logic main_in);
    mcir_pkg::req_t w;
    w.data_byte = b;
    w.from_port = port;
    w.peer_listening = peer;
    w.main_listening = main_in;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [mcir_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mcir_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic configure(input logic enable,
                           input logic [mcir_pkg::CFG_DATA_W-1:0] ident);
    drain();
    repeat (4) @(posedge clk);
    write_reg(mcir_pkg::CFG_ANSWER_ENABLE, {{(mcir_pkg::CFG_DATA_W-1){1'b0}}, enable});
    write_reg(mcir_pkg::CFG_IDENTITY_BYTES, ident);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] request_body_byte(input int unsigned j);
    logic [7:0] b;
    case (j)
      0: b = mcir_pkg::UNIV_NON_RT;
      2: b = mcir_pkg::SUB_GEN_INFO;
      3: b = mcir_pkg::SUB_ID_REQ;
      default: b = rand_byte(127);
    endcase
    return b;
  endfunction

  task automatic identity_request(input bit broken);
    int unsigned bad_pos;
    logic [7:0]  b;
    bad_pos = broken ? $urandom_range(3) : 4;
    push_byte(mcir_pkg::SYSEX_START, 1'b0, rand_bit(), rand_bit());
    for (int unsigned j = 0; j < 4; j++) begin
      if ($urandom_range(9) == 0)
        push_byte(rand_byte(255), 1'b1, rand_bit(), rand_bit());
      b = (j == bad_pos) ? rand_byte(255) : request_body_byte(j);
      push_byte(b, 1'b0, rand_bit(), rand_bit());
    end
    push_byte(mcir_pkg::SYSEX_END, 1'b0, rand_bit(), $urandom_range(4) != 0);
  endtask

  task automatic random_traffic(input int unsigned count, input bit pause_midway);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    bit          header_first;
    bit          paused;
    stop_at = words_sent + count;
    paused = 1'b0;
    while (words_sent < stop_at) begin
      if (pause_midway && !paused && stop_at - words_sent <= count / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        identity_request(pick < 12);
      end else if (pick < 85) begin
        push_byte(rand_byte(255), rand_bit(), rand_bit(), rand_bit());
      end else begin
        len = (pick < 92) ? $urandom_range(30, 36) : $urandom_range(0, 6);
        header_first = rand_bit();
        push_byte(mcir_pkg::SYSEX_START, 1'b0, rand_bit(), 1'b1);
        for (int unsigned j = 0; j < len; j++) begin
          b = (header_first && j < 4) ? request_body_byte(j) : rand_byte(127);
          push_byte(b, 1'b0, rand_bit(), 1'b1);
        end
        push_byte(mcir_pkg::SYSEX_END, 1'b0, rand_bit(), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    configure(1'b1, {mcir_pkg::CFG_DATA_W{1'b1}});

    push_byte(mcir_pkg::SYSEX_START, 1'b0, 1'b1, 1'b1);
    push_byte(mcir_pkg::UNIV_NON_RT, 1'b0, 1'b1, 1'b1);
    push_byte(8'h90, 1'b0, 1'b1, 1'b1);
    push_byte(mcir_pkg::SYSEX_START, 1'b1, 1'b1, 1'b1);
    push_byte(mcir_pkg::SUB_GEN_INFO, 1'b0, 1'b1, 1'b1);
    push_byte(mcir_pkg::SUB_ID_REQ, 1'b0, 1'b1, 1'b1);
    push_byte(mcir_pkg::SYSEX_END, 1'b0, 1'b1, 1'b1);

    push_byte(mcir_pkg::SYSEX_START, 1'b0, 1'b0, 1'b1);
    push_byte(8'h12, 1'b0, 1'b0, 1'b1);
    push_byte(mcir_pkg::SYSEX_START, 1'b0, 1'b0, 1'b1);
    push_byte(mcir_pkg::UNIV_NON_RT, 1'b0, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0, 1'b1);
    push_byte(mcir_pkg::SUB_GEN_INFO, 1'b0, 1'b0, 1'b1);
    push_byte(mcir_pkg::SUB_ID_REQ, 1'b0, 1'b0, 1'b1);
    push_byte(mcir_pkg::SYSEX_END, 1'b0, 1'b0, 1'b1);

    push_byte(mcir_pkg::SYSEX_START, 1'b0, 1'b1, 1'b1);
    push_byte(mcir_pkg::UNIV_NON_RT, 1'b0, 1'b1, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b1, 1'b1);
    push_byte(mcir_pkg::SUB_GEN_INFO, 1'b0, 1'b1, 1'b0);
    push_byte(mcir_pkg::SUB_ID_REQ, 1'b0, 1'b1, 1'b1);
    push_byte(mcir_pkg::SYSEX_END, 1'b0, 1'b1, 1'b0);

    push_byte(mcir_pkg::SYSEX_END, 1'b0, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b1, 1'b0);

    configure(1'b1, '0);
    random_traffic(16, 1'b0);

    send_idle_pct <= 79;
    configure(1'b1, rand_ident());
    random_traffic(16, 1'b1);

    send_idle_pct <= 0;
    stall_pct <= 79;
    configure(1'b0, rand_ident());
    random_traffic(16, 1'b0);

    send_idle_pct <= 38;
    stall_pct <= 38;
    configure(1'b1, rand_ident());
    random_traffic(16, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (errors == 0)
      $display("tb_midi_crossover_identity_responder: done, clean");
    else
      $display("tb_midi_crossover_identity_responder: done, errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_midi_crossover_identity_responder: done, errors");
    $finish;
  end

endmodule

### sim.f
sv/mcir_pkg.sv
sv/mcir_scan.sv
sv/midi_crossover_identity_responder.sv
sim/midi_crossover_identity_checker.sv
sim/tb_midi_crossover_identity_responder.sv
